// ===== rtl/ricl_pkg.sv =====
// Shared types and constants for the rank-indexed byte list.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ricl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RANK_W   = 6;
  localparam int CMP_W    = RANK_W + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_GET   = 2'd2,
    OP_PRINT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_EOL     = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_PRINT = 1'b1
  } state_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
    logic [7:0]       elem;
  } shift_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ricl_cell.sv =====
// One storage cell of the list chain: holds one byte, takes its left
// neighbor on insert and its right neighbor on delete. Uses ricl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ricl_cell
  import ricl_pkg::*;
(
  input  wire logic             clk,
  input  wire shift_ctrl_t      ctrl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [7:0]       left,
  input  wire logic [7:0]       right,
  output logic [7:0]            data
);

  logic [7:0] data_next;
  logic       at_pos;
  logic       after_pos;

  assign at_pos    = (idx == ctrl.pos);
  assign after_pos = (idx > ctrl.pos);

  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (at_pos) begin
        data_next = ctrl.elem;
      end else if (after_pos) begin
        data_next = left;
      end
    end else if (ctrl.del) begin
      if (at_pos || after_pos) begin
        data_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// ===== rtl/rank_indexed_char_list.sv =====
// Top level of the rank-indexed byte list: command decode, element count,
// print sequencer and result register around a chain of ricl_cell.
// Uses ricl_pkg and ricl_cell.
//
// Add and delete shift the whole cell chain in the cycle the command beat is
// accepted, and a get reads its cell through one byte mux into the result
// register. A print first enters the print state, then sends one beat per
// element plus the end-of-line beat, paced by the single result register; no
// new command is taken until it ends. A command is taken only while idle and
// the result register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none
module rank_indexed_char_list
  import ricl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [RANK_W-1:0] rank,
  input  wire logic [7:0]        elem,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [1:0]             kind,
  output logic [7:0]             ch,
  output logic                   last
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] pidx;
  logic [CNT_W-1:0] pidx_next;

  logic [7:0]       cell_data [CAPACITY];
  shift_ctrl_t      ctrl;
  logic [IDX_W-1:0] rank_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  logic             slot_free;
  logic             accept;
  logic [CMP_W-1:0] rank_x;
  logic [CMP_W-1:0] cnt_x;
  logic             is_full;
  logic             add_rank_ok;
  logic             rank_in_list;

  logic             load;
  logic [1:0]       load_kind;
  logic [7:0]       load_ch;
  logic             load_last;

  assign slot_free    = !res_valid || res_ready;
  assign cmd_ready    = (state == ST_IDLE) && slot_free;
  assign accept       = cmd_valid && cmd_ready;
  assign rank_x       = CMP_W'(rank);
  assign cnt_x        = CMP_W'(count);
  assign is_full      = (count == CNT_W'(CAPACITY));
  assign add_rank_ok  = (rank != '0) && (rank_x <= cnt_x + CMP_W'(1));
  assign rank_in_list = (rank != '0) && (rank_x <= cnt_x);
  assign rank_idx     = IDX_W'(rank - RANK_W'(1));
  assign rd_addr      = (state == ST_PRINT) ? pidx[IDX_W-1:0] : rank_idx;
  assign rd_data      = cell_data[rd_addr];

  // Cell chain
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [7:0] left_in;
      logic [7:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[gi+1];
      end
      ricl_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .idx   (IDX_W'(gi)),
        .left  (left_in),
        .right (right_in),
        .data  (cell_data[gi])
      );
    end
  endgenerate

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op_t'(opcode) == OP_PRINT)) begin
          state_next = ST_PRINT;
        end
      end
      ST_PRINT: begin
        if (slot_free && (pidx == count)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctrl       = '0;
    ctrl.pos   = rank_idx;
    ctrl.elem  = elem;
    count_next = count;
    pidx_next  = pidx;
    load       = 1'b0;
    load_kind  = KIND_BYTE;
    load_ch    = '0;
    load_last  = 1'b1;
    case (state)
      ST_IDLE: begin
        pidx_next = '0;
        if (accept) begin
          case (op_t'(opcode))
            OP_ADD: begin
              if (!add_rank_ok) begin
                load      = 1'b1;
                load_kind = KIND_INVALID;
              end else if (is_full) begin
                load      = 1'b1;
                load_kind = KIND_FULL;
              end else begin
                ctrl.ins   = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OP_DEL: begin
              if (!rank_in_list) begin
                load      = 1'b1;
                load_kind = KIND_INVALID;
              end else begin
                ctrl.del   = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
            OP_GET: begin
              load = 1'b1;
              if (!rank_in_list) begin
                load_kind = KIND_INVALID;
              end else begin
                load_ch = rd_data;
              end
            end
            OP_PRINT: begin
              load = 1'b0;
            end
            default: load = 1'b0;
          endcase
        end
      end
      ST_PRINT: begin
        if (slot_free) begin
          load = 1'b1;
          if (pidx == count) begin
            load_kind = KIND_EOL;
          end else begin
            load_ch   = rd_data;
            load_last = 1'b0;
            pidx_next = pidx + CNT_W'(1);
          end
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pidx      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pidx  <= pidx_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= load_kind;
      ch   <= load_ch;
      last <= load_last;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("element count above capacity");

  property p_print_holds_count;
    @(posedge clk) disable iff (rst) (state == ST_PRINT) |=> (count == $past(count));
  endproperty
  a_print_holds_count: assert property (p_print_holds_count)
    else $error("count changed during print");

  property p_add_grows;
    @(posedge clk) disable iff (rst)
      (accept && (op_t'(opcode) == OP_ADD) && add_rank_ok && !is_full)
      |=> (count == $past(count) + CNT_W'(1));
  endproperty
  a_add_grows: assert property (p_add_grows)
    else $error("successful add did not grow count");

  property p_nonlast_is_byte;
    @(posedge clk) disable iff (rst) (res_valid && !last) |-> (kind == KIND_BYTE);
  endproperty
  a_nonlast_is_byte: assert property (p_nonlast_is_byte)
    else $error("non-final beat is not an element byte");

endmodule
`default_nettype wire
